// ----- sv/tree_hop_distance_query_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tree hop distance query core.
// Shared forms for concurrent checks on the core's control logic.
// ----------------------------------------------------------------------------
`ifndef TREE_HOP_DISTANCE_QUERY_CORE_MACROS_SVH
`define TREE_HOP_DISTANCE_QUERY_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define THDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with the consequent in the next cycle.
`define THDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/thdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Tree hop distance query package
// Types, constants and opcodes shared by the query core.
// ----------------------------------------------------------------------------
package thdq_pkg;

  localparam int unsigned NodesDef       = 1024;
  localparam int unsigned MaxDepthDef    = 64;
  localparam int unsigned TableLevelsDef = 11;
  localparam int unsigned DistBitsDef    = 30;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned SlotW  = 11;
  localparam int unsigned LevelW = 4;
  localparam int unsigned ValueW = 30;
  localparam int unsigned OpW    = 3;

  localparam logic [ValueW-1:0] InfDist = 30'd999999999;

  typedef enum logic [OpW-1:0] {
    OP_DEPTH = 3'd0,
    OP_EULER = 3'd1,
    OP_RMQ   = 3'd2,
    OP_HCNT  = 3'd3,
    OP_HPOS  = 3'd4,
    OP_DIST  = 3'd5,
    OP_QUERY = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EPOS,
    ST_LEVEL,
    ST_RMQ,
    ST_DEPTH,
    ST_PICK,
    ST_DIRECT,
    ST_HCNT,
    ST_HPOS,
    ST_DX,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [NodeW-1:0]  node;
    logic [SlotW-1:0]  slot;
    logic [LevelW-1:0] level;
    logic [ValueW-1:0] value;
    logic [NodeW-1:0]  other_node;
  } in_t;

  typedef struct packed {
    logic [ValueW-1:0] distance;
    logic [NodeW-1:0]  common_ancestor;
  } out_t;

endpackage

// ----- sv/tree_hop_distance_query_core.sv -----
// Flow: a load is written to its table when it is taken; a query on two equal nodes goes
// straight to its result, one whose ancestor is a query node reads one stored distance, and
// any other walks the hop entries of the ancestor (up to 64 hop entries).
// Throughput: loads back to back; a query holds the input until its result transfer,
// and the next item can be taken in the cycle after that.
// Reset: asynchronous and active low; it clears control state only, tables are not cleared.
// ----------------------------------------------------------------------------
// Tree hop distance query core
// Loads a tree-decomposition hop index and answers shortest-distance queries.
// ----------------------------------------------------------------------------
`include "tree_hop_distance_query_core_macros.svh"

module tree_hop_distance_query_core #(
  parameter int unsigned NODES        = thdq_pkg::NodesDef,
  parameter int unsigned MAX_DEPTH    = thdq_pkg::MaxDepthDef,
  parameter int unsigned TABLE_LEVELS = thdq_pkg::TableLevelsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  thdq_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output thdq_pkg::out_t  out_data_o
);

  localparam int unsigned NW   = $clog2(NODES);
  localparam int unsigned CW   = NW + 1;
  localparam int unsigned DW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned HW   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LW   = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
  localparam int unsigned AW   = NW + DW;
  localparam int unsigned RW   = LW + CW;
  localparam int unsigned VW   = thdq_pkg::ValueW;

  logic [5:0]              depth_mem [NODES];
  logic [10:0]             epos_mem  [NODES];
  logic [9:0]              rmq_mem   [TABLE_LEVELS * 2 * NODES];
  logic [6:0]              hcnt_mem  [NODES];
  logic [5:0]              hpos_mem  [NODES * MAX_DEPTH];
  logic [VW-1:0]           dist_mem  [NODES * MAX_DEPTH];

  thdq_pkg::state_e state_q, state_d;
  logic [NW-1:0]  x_q, y_q, a_q, b_q, c_q;
  logic [10:0]    p_q, q_q;
  logic [LW-1:0]  k_q;
  logic [HW-1:0]  cnt_q, i_q;
  logic [5:0]     j_q;
  logic [VW-1:0]  dx_q, best_q;
  logic [5:0]     da_q, db_q;
  logic           bsel_q;
  thdq_pkg::out_t res_q;
  logic           ovalid_q;

  logic [5:0]     depth_rd_q;
  logic [10:0]    epos_rd_q;
  logic [9:0]     rmq_rd_q;
  logic [6:0]     hcnt_rd_q;
  logic [5:0]     hpos_rd_q;
  logic [VW-1:0]  dist_rd_q;

  logic [NW-1:0]  depth_ra, epos_ra, hcnt_ra;
  logic [RW-1:0]  rmq_ra;
  logic [AW-1:0]  hpos_ra, dist_ra;

  logic           acc;
  logic           is_load;
  logic [NW-1:0]  n_in;
  thdq_pkg::op_e  op_in;

  assign acc     = in_valid_i && in_ready_o;
  assign op_in   = thdq_pkg::op_e'(in_data_i.op);
  assign n_in    = NW'(in_data_i.node % NODES);
  assign is_load = acc && (op_in != thdq_pkg::OP_QUERY);

  // Write side of all tables.
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      case (op_in)
        thdq_pkg::OP_DEPTH: depth_mem[n_in] <= in_data_i.value[5:0];
        thdq_pkg::OP_EULER: epos_mem[n_in]  <= in_data_i.value[10:0];
        thdq_pkg::OP_RMQ: begin
          if (32'(in_data_i.level) < TABLE_LEVELS) begin
            rmq_mem[RW'(in_data_i.level) * RW'(2 * NODES)
                    + RW'(in_data_i.slot % (2 * NODES))] <= in_data_i.value[9:0];
          end
        end
        thdq_pkg::OP_HCNT: hcnt_mem[n_in] <= in_data_i.value[6:0];
        thdq_pkg::OP_HPOS: begin
          if (32'(in_data_i.slot) < MAX_DEPTH) begin
            hpos_mem[AW'(n_in) * AW'(MAX_DEPTH) + AW'(in_data_i.slot)] <=
              in_data_i.value[5:0];
          end
        end
        thdq_pkg::OP_DIST: begin
          if (32'(in_data_i.slot) < MAX_DEPTH) begin
            dist_mem[AW'(n_in) * AW'(MAX_DEPTH) + AW'(in_data_i.slot)] <=
              in_data_i.value;
          end
        end
        default: ;
      endcase
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    depth_rd_q <= depth_mem[depth_ra];
    epos_rd_q  <= epos_mem[epos_ra];
    rmq_rd_q   <= rmq_mem[rmq_ra];
    hcnt_rd_q  <= hcnt_mem[hcnt_ra];
    hpos_rd_q  <= hpos_mem[hpos_ra];
    dist_rd_q  <= dist_mem[dist_ra];
  end

  logic [10:0] lo, hi, len1, q2;
  logic [LW-1:0] klog, k_use;
  logic [NW-1:0] c_sel;
  logic [AW-1:0] hop_base;
  logic [VW:0]   sum;

  always_comb begin
    lo   = (p_q > q_q) ? q_q : p_q;
    hi   = (p_q > q_q) ? p_q : q_q;
    len1 = hi - lo;
    klog = '0;
    for (int t = 1; t < 11; t++) begin
      if (len1 >= 11'(1 << t)) klog = LW'(t);
    end
    if (32'(klog) >= TABLE_LEVELS) klog = LW'(TABLE_LEVELS - 1);
    k_use    = (state_q == thdq_pkg::ST_RMQ && !bsel_q) ? klog : k_q;
    q2       = hi - 11'(1 << k_q) + 11'd1;
    c_sel    = (da_q < depth_rd_q) ? a_q : b_q;
    hop_base = AW'(c_q) * AW'(MAX_DEPTH);
    sum      = {1'b0, dx_q} + {1'b0, dist_rd_q};
  end

  // Read addresses follow the sequencer state.
  always_comb begin
    epos_ra  = (state_q == thdq_pkg::ST_IDLE) ? n_in : y_q;
    depth_ra = bsel_q ? b_q : a_q;
    hcnt_ra  = c_q;
    rmq_ra   = RW'(k_use) * RW'(2 * NODES) + RW'((bsel_q ? q2 : lo) % (2 * NODES));
    hpos_ra  = hop_base + AW'(i_q);
    dist_ra  = AW'(x_q) * AW'(MAX_DEPTH) + AW'(j_q);
    case (state_q)
      thdq_pkg::ST_DIRECT: dist_ra = AW'(c_q == x_q ? y_q : x_q) * AW'(MAX_DEPTH)
                                     + AW'(c_q == a_q ? da_q : db_q);
      thdq_pkg::ST_DX:     dist_ra = AW'(y_q) * AW'(MAX_DEPTH) + AW'(j_q);
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      thdq_pkg::ST_IDLE:
        if (acc && op_in == thdq_pkg::OP_QUERY) begin
          state_d = (n_in == NW'(in_data_i.other_node % NODES)) ? thdq_pkg::ST_OUT
                                                                 : thdq_pkg::ST_EPOS;
        end
      thdq_pkg::ST_EPOS:   state_d = thdq_pkg::ST_LEVEL;
      thdq_pkg::ST_LEVEL:  state_d = thdq_pkg::ST_RMQ;
      thdq_pkg::ST_RMQ:    state_d = bsel_q ? thdq_pkg::ST_DEPTH : thdq_pkg::ST_RMQ;
      thdq_pkg::ST_DEPTH:  state_d = bsel_q ? thdq_pkg::ST_PICK : thdq_pkg::ST_DEPTH;
      thdq_pkg::ST_PICK:
        state_d = (c_sel == x_q || c_sel == y_q) ? thdq_pkg::ST_DIRECT : thdq_pkg::ST_HCNT;
      thdq_pkg::ST_DIRECT: state_d = bsel_q ? thdq_pkg::ST_OUT : thdq_pkg::ST_DIRECT;
      thdq_pkg::ST_HCNT:   state_d = bsel_q ? thdq_pkg::ST_HPOS : thdq_pkg::ST_HCNT;
      thdq_pkg::ST_HPOS:
        if (i_q >= cnt_q) state_d = thdq_pkg::ST_OUT;
        else if (bsel_q) state_d = thdq_pkg::ST_DX;
      thdq_pkg::ST_DX:     state_d = bsel_q ? thdq_pkg::ST_SUM : thdq_pkg::ST_DX;
      thdq_pkg::ST_SUM:    state_d = bsel_q ? thdq_pkg::ST_HPOS : thdq_pkg::ST_SUM;
      thdq_pkg::ST_OUT:    if (ovalid_q && out_ready_i) state_d = thdq_pkg::ST_IDLE;
      default:             state_d = thdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == thdq_pkg::ST_IDLE);
    out_valid_o = ovalid_q;
    out_data_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= thdq_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      bsel_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= (state_q == thdq_pkg::ST_OUT) && !(ovalid_q && out_ready_i);
      case (state_q)
        thdq_pkg::ST_IDLE: bsel_q <= 1'b0;
        thdq_pkg::ST_RMQ, thdq_pkg::ST_DEPTH, thdq_pkg::ST_DIRECT, thdq_pkg::ST_HCNT,
        thdq_pkg::ST_DX, thdq_pkg::ST_SUM: bsel_q <= ~bsel_q;
        thdq_pkg::ST_HPOS: bsel_q <= (i_q >= cnt_q) ? 1'b0 : ~bsel_q;
        thdq_pkg::ST_OUT: bsel_q <= 1'b0;
        default: bsel_q <= 1'b0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      thdq_pkg::ST_IDLE: begin
        x_q <= n_in;
        y_q <= NW'(in_data_i.other_node % NODES);
        c_q <= n_in;
        best_q <= '0;
        i_q <= '0;
      end
      thdq_pkg::ST_EPOS: p_q <= epos_rd_q;
      thdq_pkg::ST_LEVEL: begin
        q_q <= epos_rd_q;
      end
      thdq_pkg::ST_RMQ: begin
        if (!bsel_q) k_q <= klog;
        else a_q <= NW'(rmq_rd_q % NODES);
      end
      default: ;
    endcase
    case (state_q)
      thdq_pkg::ST_DEPTH: begin
        if (!bsel_q) begin
          b_q <= NW'(rmq_rd_q % NODES);
        end else begin
          da_q <= depth_rd_q;
        end
      end
      thdq_pkg::ST_PICK: begin
        db_q <= depth_rd_q;
        c_q  <= c_sel;
        best_q <= thdq_pkg::InfDist;
      end
      thdq_pkg::ST_DIRECT: begin
        if (bsel_q) begin
          if (32'(c_q == a_q ? da_q : db_q) >= MAX_DEPTH) best_q <= thdq_pkg::InfDist;
          else best_q <= dist_rd_q;
        end
      end
      thdq_pkg::ST_HCNT: begin
        if (bsel_q) cnt_q <= (32'(hcnt_rd_q) > MAX_DEPTH) ? HW'(MAX_DEPTH) : HW'(hcnt_rd_q);
        i_q <= '0;
      end
      thdq_pkg::ST_HPOS: if (bsel_q) j_q <= hpos_rd_q;
      thdq_pkg::ST_DX: if (bsel_q) dx_q <= dist_rd_q;
      thdq_pkg::ST_SUM: begin
        if (bsel_q) begin
          if (32'(j_q) < MAX_DEPTH && sum < {1'b0, best_q}) best_q <= sum[VW-1:0];
          i_q <= i_q + HW'(1);
        end
      end
      thdq_pkg::ST_OUT: begin
        if (!ovalid_q) begin
          res_q.distance        <= best_q;
          res_q.common_ancestor <= 10'(c_q);
        end
      end
      default: ;
    endcase
  end

  `THDQ_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni,
                   state_q != thdq_pkg::ST_IDLE, !in_ready_o)
  `THDQ_ASSERT_IMP(a_out_only_in_out, clk_i, rst_ni,
                   out_valid_o, state_q == thdq_pkg::ST_OUT)
  `THDQ_ASSERT_NEXT(a_walk_bounded, clk_i, rst_ni,
                    state_q == thdq_pkg::ST_SUM, i_q <= cnt_q)

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the tree hop distance query core
// Loads hop index tables through the input channel and checks every query
// result against a predictor of the core. Before each query the tables it
// will read are filled, so no unwritten entry is ever read. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Nodes    = thdq_pkg::NodesDef;
  localparam int unsigned MaxDepth = thdq_pkg::MaxDepthDef;
  localparam int unsigned Levels   = thdq_pkg::TableLevelsDef;
  localparam int unsigned Cols     = 2 * Nodes;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  thdq_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  thdq_pkg::out_t out_data_o;

  tree_hop_distance_query_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the index tables with a written flag per entry.
  logic [5:0]  depth_tab [Nodes];
  logic [10:0] euler_tab [Nodes];
  logic [9:0]  rmq_tab   [Levels*Cols];
  logic [6:0]  hcnt_tab  [Nodes];
  logic [5:0]  hpos_tab  [Nodes*MaxDepth];
  logic [29:0] adist_tab [Nodes*MaxDepth];
  bit depth_wr [Nodes];
  bit euler_wr [Nodes];
  bit rmq_wr   [Levels*Cols];
  bit hcnt_wr  [Nodes];
  bit hpos_wr  [Nodes*MaxDepth];
  bit adist_wr [Nodes*MaxDepth];

  thdq_pkg::out_t pending_answers[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   items_sent = 0;
  bit   no_idle = 1'b0;
  logic [9:0] pool [12];

  function automatic void rmq_addrs(input logic [9:0] n, input logic [9:0] m,
                                    output int ra, output int rb);
    int p, q, len, k, q2;
    p = euler_tab[n];
    q = euler_tab[m];
    if (p > q) begin
      len = p; p = q; q = len;
    end
    len = q - p + 1;
    k = 0;
    if (len > 1) begin
      while (((len - 1) >> (k + 1)) != 0) k++;
    end
    if (k >= Levels) k = Levels - 1;
    q2 = q - (1 << k) + 1;
    ra = k * Cols + (p % Cols);
    rb = k * Cols + (q2 % Cols);
  endfunction

  function automatic logic [9:0] ancestor_of(input logic [9:0] n, input logic [9:0] m);
    int ra, rb;
    logic [9:0] a, b;
    rmq_addrs(n, m, ra, rb);
    a = rmq_tab[ra];
    b = rmq_tab[rb];
    return (depth_tab[a] < depth_tab[b]) ? a : b;
  endfunction

  function automatic thdq_pkg::out_t hop_distance(input logic [9:0] n, input logic [9:0] m);
    thdq_pkg::out_t r;
    logic [9:0] c;
    int cnt, j;
    longint s, best;
    if (n == m) begin
      r.distance = '0;
      r.common_ancestor = n;
      return r;
    end
    c = ancestor_of(n, m);
    if (c == n || c == m) begin
      j = depth_tab[c];
      best = (j >= MaxDepth) ? thdq_pkg::InfDist
                             : adist_tab[(c == n ? m : n) * MaxDepth + j];
    end else begin
      cnt = hcnt_tab[c];
      if (cnt > MaxDepth) cnt = MaxDepth;
      best = thdq_pkg::InfDist;
      for (int i = 0; i < cnt; i++) begin
        j = hpos_tab[c * MaxDepth + i];
        s = longint'(adist_tab[n * MaxDepth + j]) + longint'(adist_tab[m * MaxDepth + j]);
        if (s < best) best = s;
      end
    end
    r.distance = best[29:0];
    r.common_ancestor = c;
    return r;
  endfunction

  function automatic void apply_item(input thdq_pkg::in_t it);
    case (thdq_pkg::op_e'(it.op))
      thdq_pkg::OP_DEPTH: begin
        depth_tab[it.node] = it.value[5:0]; depth_wr[it.node] = 1'b1;
      end
      thdq_pkg::OP_EULER: begin
        euler_tab[it.node] = it.value[10:0]; euler_wr[it.node] = 1'b1;
      end
      thdq_pkg::OP_RMQ: if (it.level < Levels) begin
        rmq_tab[it.level * Cols + it.slot] = it.value[9:0];
        rmq_wr[it.level * Cols + it.slot] = 1'b1;
      end
      thdq_pkg::OP_HCNT: begin
        hcnt_tab[it.node] = it.value[6:0]; hcnt_wr[it.node] = 1'b1;
      end
      thdq_pkg::OP_HPOS: if (it.slot < MaxDepth) begin
        hpos_tab[it.node * MaxDepth + it.slot] = it.value[5:0];
        hpos_wr[it.node * MaxDepth + it.slot] = 1'b1;
      end
      thdq_pkg::OP_DIST: if (it.slot < MaxDepth) begin
        adist_tab[it.node * MaxDepth + it.slot] = it.value;
        adist_wr[it.node * MaxDepth + it.slot] = 1'b1;
      end
      thdq_pkg::OP_QUERY:
        pending_answers = {pending_answers, hop_distance(it.node, it.other_node)};
      default: ;
    endcase
  endfunction

  // Valid is lowered only when a gap follows, so it is never dropped and
  // raised again in one time step.
  task automatic send_item(input thdq_pkg::in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(it);
    items_sent++;
  endtask

  task automatic load(input thdq_pkg::op_e op, input int node, input int slot,
                      input int level, input int value);
    thdq_pkg::in_t it;
    it.op = op;
    it.node = node[9:0];
    it.slot = slot[10:0];
    it.level = level[3:0];
    it.value = value[29:0];
    it.other_node = $urandom_range(0, 1023);
    send_item(it);
  endtask

  function automatic int rand_value(input int lo, input int hi);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999999999) : $urandom_range(lo, hi);
  endfunction

  function automatic int rand_distance();
    case ($urandom_range(0, 3))
      0: return $urandom_range(500000000, 999999999);
      1: return $urandom_range(0, 999999999);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // Fills every entry the query will read and then sends the query.
  task automatic resolved_query(input logic [9:0] n, input logic [9:0] m);
    int ra, rb, j, cnt;
    logic [9:0] c;
    thdq_pkg::in_t it;
    if (n != m) begin
      if (!euler_wr[n]) load(thdq_pkg::OP_EULER, n, 0, 0, rand_value(0, 2047));
      if (!euler_wr[m]) load(thdq_pkg::OP_EULER, m, 0, 0, rand_value(0, 2047));
      rmq_addrs(n, m, ra, rb);
      if (!rmq_wr[ra])
        load(thdq_pkg::OP_RMQ, 0, ra % Cols, ra / Cols,
             int'({10'($urandom_range(0, 1023)), pool[$urandom_range(0, 11)]}));
      if (!rmq_wr[rb])
        load(thdq_pkg::OP_RMQ, 0, rb % Cols, rb / Cols,
             int'({10'($urandom_range(0, 1023)), pool[$urandom_range(0, 11)]}));
      if (!depth_wr[rmq_tab[ra]])
        load(thdq_pkg::OP_DEPTH, rmq_tab[ra], 0, 0, rand_value(0, 63));
      if (!depth_wr[rmq_tab[rb]])
        load(thdq_pkg::OP_DEPTH, rmq_tab[rb], 0, 0, rand_value(0, 63));
      c = ancestor_of(n, m);
      if (c == n || c == m) begin
        j = (c == n ? m : n) * MaxDepth + depth_tab[c];
        if (!adist_wr[j])
          load(thdq_pkg::OP_DIST, j / MaxDepth, j % MaxDepth, 0, rand_distance());
      end else begin
        if (!hcnt_wr[c]) load(thdq_pkg::OP_HCNT, c, 0, 0, rand_value(0, 6));
        cnt = (hcnt_tab[c] > MaxDepth) ? MaxDepth : hcnt_tab[c];
        for (int i = 0; i < cnt; i++) begin
          if (!hpos_wr[c * MaxDepth + i])
            load(thdq_pkg::OP_HPOS, c, i, 0, rand_value(0, 63));
          j = hpos_tab[c * MaxDepth + i];
          if (!adist_wr[n * MaxDepth + j]) load(thdq_pkg::OP_DIST, n, j, 0, rand_distance());
          if (!adist_wr[m * MaxDepth + j]) load(thdq_pkg::OP_DIST, m, j, 0, rand_distance());
        end
      end
    end
    it.op = thdq_pkg::OP_QUERY;
    it.node = n;
    it.other_node = m;
    it.slot = $urandom_range(0, 2047);
    it.level = $urandom_range(0, 15);
    it.value = $urandom_range(0, 999999999);
    send_item(it);
  endtask

  task automatic new_pool();
    foreach (pool[i]) pool[i] = $urandom_range(0, 1023);
    pool[0] = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 5))
      0: load(thdq_pkg::OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 2047),
              $urandom_range(0, 15), $urandom_range(0, 999999999));
      1: load(thdq_pkg::OP_RMQ, $urandom_range(0, 1023), $urandom_range(0, 2047),
              $urandom_range(11, 15), $urandom_range(0, 999999999));
      2: load(thdq_pkg::OP_HPOS, pool[$urandom_range(0, 11)], $urandom_range(64, 2047), 0,
              $urandom_range(0, 999999999));
      3: load(thdq_pkg::OP_DIST, pool[$urandom_range(0, 11)], $urandom_range(64, 2047), 0,
              $urandom_range(0, 999999999));
      4: load(thdq_pkg::OP_DEPTH, pool[$urandom_range(0, 11)], 0, 0, rand_value(0, 63));
      default: load(thdq_pkg::OP_HCNT, pool[$urandom_range(0, 11)], 0, 0, rand_value(0, 8));
    endcase
  endtask

  task automatic test_directed();
    new_pool();
    pool[1] = 10'd1; pool[2] = 10'd2; pool[3] = 10'd5;
    load(thdq_pkg::OP_NONE, 1, 3, 0, 999999999);
    load(thdq_pkg::OP_RMQ, 1, 2047, 11, 5);
    load(thdq_pkg::OP_RMQ, 1, 0, 15, 5);
    load(thdq_pkg::OP_HPOS, 5, 64, 0, 1);
    load(thdq_pkg::OP_DIST, 5, 2047, 0, 1);
    resolved_query(10'd0, 10'd0);
    resolved_query(10'd1023, 10'd1023);
    load(thdq_pkg::OP_DEPTH, 5, 0, 0, 0);
    load(thdq_pkg::OP_DEPTH, 1, 0, 0, 3);
    load(thdq_pkg::OP_DEPTH, 2, 0, 0, 999999999);
    load(thdq_pkg::OP_EULER, 1, 0, 0, 10);
    load(thdq_pkg::OP_EULER, 2, 0, 0, 20);
    load(thdq_pkg::OP_RMQ, 0, 10, 3, 5);
    load(thdq_pkg::OP_RMQ, 0, 13, 3, 5);
    load(thdq_pkg::OP_HCNT, 5, 0, 0, 0);
    resolved_query(10'd1, 10'd2);
    load(thdq_pkg::OP_HCNT, 5, 0, 0, 999999999);
    resolved_query(10'd2, 10'd1);
    load(thdq_pkg::OP_RMQ, 0, 10, 3, 1);
    resolved_query(10'd1, 10'd2);
    load(thdq_pkg::OP_EULER, 1, 0, 0, 0);
    load(thdq_pkg::OP_EULER, 2, 0, 0, 2047);
    resolved_query(10'd1, 10'd2);
  endtask

  task automatic test_random_queries(input int target, input bit steady);
    no_idle = steady;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) == 0) new_pool();
      if ($urandom_range(0, 9) == 0) noise_item();
      else resolved_query(pool[$urandom_range(0, 11)], pool[$urandom_range(0, 11)]);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    thdq_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = pending_answers.pop_front();
        if (out_data_o.distance !== want.distance ||
            out_data_o.common_ancestor !== want.common_ancestor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: distance %0d ancestor %0d, expected %0d ancestor %0d",
                     out_data_o.distance, out_data_o.common_ancestor,
                     want.distance, want.common_ancestor);
        end
      end
    end
  end

  // Result side: after each transfer the receiver may stall for a while.
  initial begin
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    new_pool();
    test_random_queries(900, 1'b0);
    new_pool();
    test_random_queries(1300, 1'b1);
    new_pool();
    test_random_queries(1950, 1'b0);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
